// ----- rtl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotation unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// vector component format (signed, 16 fraction bits)
	localparam int VEC_WIDTH       = 32;
	// default orientation component width (signed Q2.(QUAT_WIDTH-2))
	localparam int QUAT_WIDTH_DEF  = 18;
	// apb address width: four 32-bit registers
	localparam int ADDR_WIDTH      = 4;
	localparam int DATA_WIDTH      = 32;
	// cycles from accepted start to the done strobe
	localparam int LATENCY         = 6;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_ORIENT_W = 2'd0;
	localparam logic [1:0] REG_ORIENT_X = 2'd1;
	localparam logic [1:0] REG_ORIENT_Y = 2'd2;
	localparam logic [1:0] REG_ORIENT_Z = 2'd3;

	// saturation limits
	localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [VEC_WIDTH-1:0] vec_x;
		logic signed [VEC_WIDTH-1:0] vec_y;
		logic signed [VEC_WIDTH-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [VEC_WIDTH-1:0] rot_x;
		logic signed [VEC_WIDTH-1:0] rot_y;
		logic signed [VEC_WIDTH-1:0] rot_z;
		logic                        saturated;
	} rot_t;

endpackage

// ----- rtl/quaternion_vector_rotation_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_unit
// Rotates a stream of 3-vectors by the orientation quaternion q held in four
// APB registers, returning the imaginary part of q*(0,v)*conj(q).
// ----------------------------------------------------------------------------
// Usage:
//   - program orient_w/x/y/z (byte addresses 0x0, 0x4, 0x8, 0xC) over APB
//     while no transaction is in flight; reset leaves q at identity (w = 1.0)
//   - drive vec and pulse start; a transaction is taken on every edge with
//     start high, busy is always low so a new vector may enter every cycle
//   - the result appears on result with done high for exactly one cycle,
//     registered at the end of the pipeline; results leave in order
//   - throughput is one vector per cycle, set by the six-stage pipeline:
//     quaternion products, rotation matrix, split partial products,
//     entry products, row sums, round and saturate
//   - the receiver has no back pressure; it must take every done cycle
//   - a non-unit q scales the vector by |q|^2; components beyond the
//     output range are clamped and flagged in result.saturated
//   - asynchronous reset clears the pipeline valid bits and the done strobe
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_unit #(
	parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            start,
	output logic                            busy,
	input  qvr_pkg::vec_t                   vec,
	output logic                            done,
	output qvr_pkg::rot_t                   result,
	// apb configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [qvr_pkg::ADDR_WIDTH-1:0]  paddr,
	input  logic [qvr_pkg::DATA_WIDTH-1:0]  pwdata,
	output logic [qvr_pkg::DATA_WIDTH-1:0]  prdata,
	output logic                            pready
);

	localparam int VW  = qvr_pkg::VEC_WIDTH;
	localparam int QW  = QUAT_WIDTH;
	localparam int PW  = 2 * QW;            // quaternion products
	localparam int MW  = 2 * QW + 2;        // rotation matrix entries
	localparam int LB  = MW / 2;            // low split of a matrix entry
	localparam int HB  = MW - LB;           // high split of a matrix entry
	localparam int LOW = LB + 1 + VW;       // low partial product
	localparam int HIW = HB + VW;           // high partial product
	localparam int EW  = MW + VW;           // full entry product
	localparam int AW  = EW + 2;            // row sum
	localparam int SH  = 2 * (QW - 2);      // extra fraction bits
	localparam int RW  = AW - SH;           // rounded width
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SH - 1);
	localparam logic signed [QW-1:0] ONE  = QW'(1) <<< (QW - 2);

	// orientation registers
	logic signed [QW-1:0] orient_q [4];
	logic                 wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite && pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q[0] <= ONE;
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				qvr_pkg::REG_ORIENT_W: orient_q[0] <= pwdata[QW-1:0];
				qvr_pkg::REG_ORIENT_X: orient_q[1] <= pwdata[QW-1:0];
				qvr_pkg::REG_ORIENT_Y: orient_q[2] <= pwdata[QW-1:0];
				qvr_pkg::REG_ORIENT_Z: orient_q[3] <= pwdata[QW-1:0];
				default: ;
			endcase
		end
	end

	// register read, sign extended
	always_comb begin
		case (paddr[3:2])
			qvr_pkg::REG_ORIENT_W: prdata = qvr_pkg::DATA_WIDTH'(orient_q[0]);
			qvr_pkg::REG_ORIENT_X: prdata = qvr_pkg::DATA_WIDTH'(orient_q[1]);
			qvr_pkg::REG_ORIENT_Y: prdata = qvr_pkg::DATA_WIDTH'(orient_q[2]);
			qvr_pkg::REG_ORIENT_Z: prdata = qvr_pkg::DATA_WIDTH'(orient_q[3]);
			default:               prdata = '0;
		endcase
	end

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done_q <= vld_s5;
		end
	end

	// stage 1: quaternion products, capture vector
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1;
	logic signed [PW-1:0] xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [VW-1:0] v_s1 [3];
	logic signed [VW-1:0] v_s2 [3];

	always_ff @(posedge clk) begin
		ww_s1   <= orient_q[0] * orient_q[0];
		xx_s1   <= orient_q[1] * orient_q[1];
		yy_s1   <= orient_q[2] * orient_q[2];
		zz_s1   <= orient_q[3] * orient_q[3];
		xy_s1   <= orient_q[1] * orient_q[2];
		xz_s1   <= orient_q[1] * orient_q[3];
		yz_s1   <= orient_q[2] * orient_q[3];
		wx_s1   <= orient_q[0] * orient_q[1];
		wy_s1   <= orient_q[0] * orient_q[2];
		wz_s1   <= orient_q[0] * orient_q[3];
		v_s1[0] <= vec.vec_x;
		v_s1[1] <= vec.vec_y;
		v_s1[2] <= vec.vec_z;
		v_s2    <= v_s1;
	end

	// stage 2: rotation matrix, row major
	logic signed [MW-1:0] m_s2 [9];

	always_ff @(posedge clk) begin
		m_s2[0] <= MW'(ww_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
		m_s2[1] <= (MW'(xy_s1) - MW'(wz_s1)) <<< 1;
		m_s2[2] <= (MW'(xz_s1) + MW'(wy_s1)) <<< 1;
		m_s2[3] <= (MW'(xy_s1) + MW'(wz_s1)) <<< 1;
		m_s2[4] <= MW'(ww_s1) - MW'(xx_s1) + MW'(yy_s1) - MW'(zz_s1);
		m_s2[5] <= (MW'(yz_s1) - MW'(wx_s1)) <<< 1;
		m_s2[6] <= (MW'(xz_s1) - MW'(wy_s1)) <<< 1;
		m_s2[7] <= (MW'(yz_s1) + MW'(wx_s1)) <<< 1;
		m_s2[8] <= MW'(ww_s1) - MW'(xx_s1) - MW'(yy_s1) + MW'(zz_s1);
	end

	// stages 3 and 4: each entry times its vector component, in two halves
	logic signed [LOW-1:0] lo_s3 [9];
	logic signed [HIW-1:0] hi_s3 [9];
	logic signed [EW-1:0]  e_s4  [9];

	for (genvar gi = 0; gi < 9; gi++) begin : g_entry
		always_ff @(posedge clk) begin
			lo_s3[gi] <= $signed({1'b0, m_s2[gi][LB-1:0]}) * v_s2[gi % 3];
			hi_s3[gi] <= $signed(m_s2[gi][MW-1:LB]) * v_s2[gi % 3];
			e_s4[gi]  <= (EW'(hi_s3[gi]) <<< LB) + EW'(lo_s3[gi]);
		end
	end

	// stage 5: row sums; output stage: round half up and clamp
	logic signed [AW-1:0]  acc_s5  [3];
	logic signed [VW-1:0]  rot_d   [3];
	logic [2:0]            sat_d;
	logic signed [VW-1:0]  rot_q   [3];
	logic                  sat_q;

	for (genvar gr = 0; gr < 3; gr++) begin : g_row
		logic signed [AW-1:0] rnd;
		logic signed [RW-1:0] shr;

		always_ff @(posedge clk) begin
			acc_s5[gr] <= AW'(e_s4[3*gr]) + AW'(e_s4[3*gr+1]) + AW'(e_s4[3*gr+2]);
		end

		// clamp when the bits above the output sign differ from it
		always_comb begin
			rnd = acc_s5[gr] + HALF;
			shr = RW'(rnd >>> SH);
			if ((&shr[RW-1:VW-1]) || !(|shr[RW-1:VW-1])) begin
				rot_d[gr] = shr[VW-1:0];
				sat_d[gr] = 1'b0;
			end else if (shr[RW-1]) begin
				rot_d[gr] = qvr_pkg::VEC_MIN;
				sat_d[gr] = 1'b1;
			end else begin
				rot_d[gr] = qvr_pkg::VEC_MAX;
				sat_d[gr] = 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		rot_q <= rot_d;
		sat_q <= |sat_d;
	end

	assign done             = done_q;
	assign result.rot_x     = rot_q[0];
	assign result.rot_y     = rot_q[1];
	assign result.rot_z     = rot_q[2];
	assign result.saturated = sat_q;

endmodule

// ----- rtl/qvr_checker.sv -----
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks for the quaternion vector rotation unit.
// ----------------------------------------------------------------------------
module qvr_checker #(
	parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input qvr_pkg::rot_t                   result,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [qvr_pkg::ADDR_WIDTH-1:0]  paddr,
	input logic [qvr_pkg::DATA_WIDTH-1:0]  pwdata,
	input logic [qvr_pkg::DATA_WIDTH-1:0]  prdata,
	input logic                            pready
);

	// every accepted transaction gives a done strobe after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(qvr_pkg::LATENCY) done)
		else $error("done missing after accepted transaction");

	// no done strobe without a transaction behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(qvr_pkg::LATENCY) !done)
		else $error("done without accepted transaction");

	// a saturated result carries at least one clamped component
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.rot_x == qvr_pkg::VEC_MAX || result.rot_x == qvr_pkg::VEC_MIN ||
			 result.rot_y == qvr_pkg::VEC_MAX || result.rot_y == qvr_pkg::VEC_MIN ||
			 result.rot_z == qvr_pkg::VEC_MAX || result.rot_z == qvr_pkg::VEC_MIN))
		else $error("saturated flag without clamped component");

	// a register read straight after a write returns the low QUAT_WIDTH bits of the written value
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		($past(psel && penable && pwrite && pready) && psel && !pwrite &&
		 paddr == $past(paddr)) |-> prdata[QUAT_WIDTH-1:0] == $past(pwdata[QUAT_WIDTH-1:0]))
		else $error("register readback mismatch");

endmodule

bind quaternion_vector_rotation_unit qvr_checker #(
	.QUAT_WIDTH (QUAT_WIDTH)
) u_qvr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pready  (pready)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion vector rotation unit. A short table
// of directed vectors and orientations is followed by random phases, each
// with its own orientation written over apb while the pipeline is empty.
// Every accepted transaction is predicted in bit-exact fixed point or takes a
// known result from the table; done results are compared in order against these.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qvr_pkg::*;

	localparam int QW      = QUAT_WIDTH_DEF;
	localparam int QFRAC   = QW - 2;
	localparam int PROD_W  = 2 * QW;
	localparam int ACC_W   = 96;
	localparam int NUM_DIR = 24;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 170;

	// orientation values in Q2.16
	localparam logic signed [QW-1:0] Q_ZERO = '0;
	localparam logic signed [QW-1:0] Q_ONE  = 18'sd65536;
	localparam logic signed [QW-1:0] Q_NONE = -18'sd65536;
	localparam logic signed [QW-1:0] Q_MAX  = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN  = {1'b1, {(QW-1){1'b0}}};
	localparam logic signed [QW-1:0] Q_C45  = 18'sd46341;
	localparam logic signed [QW-1:0] Q_TINY = 18'sd1;

	// vector values in Q16.16
	localparam logic signed [VEC_WIDTH-1:0] V_ONE  = 32'sh0001_0000;
	localparam logic signed [VEC_WIDTH-1:0] V_NEG1 = -32'sd1;

	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (2*QFRAC - 1);

	typedef struct packed {
		logic signed [QW-1:0] qw;
		logic signed [QW-1:0] qx;
		logic signed [QW-1:0] qy;
		logic signed [QW-1:0] qz;
		vec_t                 v;
		logic                 chk;
		rot_t                 known;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	vec_t                  vec = '0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [DATA_WIDTH-1:0] pwdata = '0;
	logic                  busy;
	logic                  done;
	rot_t                  result;
	logic [DATA_WIDTH-1:0] prdata;
	logic                  pready;

	// typed expectation travels with the transaction it belongs to
	logic                  known_sel = 1'b0;
	rot_t                  known_rot = '0;

	// bench copy of the orientation registers
	logic signed [QW-1:0]  ori_w = Q_ONE;
	logic signed [QW-1:0]  ori_x = Q_ZERO;
	logic signed [QW-1:0]  ori_y = Q_ZERO;
	logic signed [QW-1:0]  ori_z = Q_ZERO;

	rot_t                  pending_rot [$];
	rot_t                  want;
	int                    errors = 0;
	int                    idle_pct = 7;
	dir_row_t              dir_rows [NUM_DIR];

	quaternion_vector_rotation_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.vec     (vec),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// sign-extended product at accumulator width
	function automatic logic signed [ACC_W-1:0] wide_mul(input logic signed [PROD_W-1:0] p,
			input logic signed [VEC_WIDTH-1:0] c);
		logic signed [ACC_W-1:0] pe;
		logic signed [ACC_W-1:0] ce;
		pe = p;
		ce = c;
		return pe * ce;
	endfunction

	// round half up to 16 fraction bits, then clamp to the vector range
	function automatic logic signed [VEC_WIDTH-1:0] round_clamp(input logic signed [ACC_W-1:0] acc,
			inout logic sat);
		logic signed [ACC_W-1:0] r;
		r = (acc + ROUND_HALF) >>> (2*QFRAC);
		if (r > VEC_MAX) begin
			sat = 1'b1;
			return VEC_MAX;
		end
		if (r < VEC_MIN) begin
			sat = 1'b1;
			return VEC_MIN;
		end
		return r[VEC_WIDTH-1:0];
	endfunction

	// q*(0,v)*conj(q) in matrix form with the current orientation
	function automatic rot_t rotate_vec(input vec_t v);
		logic signed [PROD_W-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		logic signed [VEC_WIDTH-1:0] vx, vy, vz;
		logic signed [ACC_W-1:0] ax, ay, az;
		logic sat;
		rot_t r;
		vx = v.vec_x;
		vy = v.vec_y;
		vz = v.vec_z;
		ww = ori_w * ori_w;
		xx = ori_x * ori_x;
		yy = ori_y * ori_y;
		zz = ori_z * ori_z;
		xy = ori_x * ori_y;
		xz = ori_x * ori_z;
		yz = ori_y * ori_z;
		wx = ori_w * ori_x;
		wy = ori_w * ori_y;
		wz = ori_w * ori_z;
		ax = wide_mul(ww, vx) + wide_mul(xx, vx) - wide_mul(yy, vx) - wide_mul(zz, vx)
			+ 2 * (wide_mul(xy, vy) - wide_mul(wz, vy) + wide_mul(xz, vz) + wide_mul(wy, vz));
		ay = wide_mul(ww, vy) - wide_mul(xx, vy) + wide_mul(yy, vy) - wide_mul(zz, vy)
			+ 2 * (wide_mul(xy, vx) + wide_mul(wz, vx) + wide_mul(yz, vz) - wide_mul(wx, vz));
		az = wide_mul(ww, vz) - wide_mul(xx, vz) - wide_mul(yy, vz) + wide_mul(zz, vz)
			+ 2 * (wide_mul(xz, vx) - wide_mul(wy, vx) + wide_mul(yz, vy) + wide_mul(wx, vy));
		sat = 1'b0;
		r.rot_x = round_clamp(ax, sat);
		r.rot_y = round_clamp(ay, sat);
		r.rot_z = round_clamp(az, sat);
		r.saturated = sat;
		return r;
	endfunction

	// random vector component: full range, small, scaled or extreme
	function automatic logic signed [VEC_WIDTH-1:0] rand_comp();
		logic signed [VEC_WIDTH-1:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = $urandom;
			4, 5, 6, 7: c = $signed(32'($urandom_range(0, 2097152))) - 32'sd1048576;
			8: begin
				c = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					c = -c;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: c = VEC_MAX;
					1: c = VEC_MIN;
					2: c = '0;
					3: c = V_ONE;
					default: c = V_NEG1;
				endcase
			end
		endcase
		return c;
	endfunction

	// random orientation component: full range, within +-1.0, extreme or tiny
	function automatic logic signed [QW-1:0] rand_quat();
		logic signed [QW-1:0] c;
		case ($urandom_range(0, 5))
			0, 1: c = QW'($urandom);
			2, 3: c = QW'($urandom_range(0, 131072)) - Q_ONE;
			4: begin
				case ($urandom_range(0, 4))
					0: c = Q_MAX;
					1: c = Q_MIN;
					2: c = Q_ZERO;
					3: c = Q_ONE;
					default: c = Q_NONE;
				endcase
			end
			default: c = QW'($urandom_range(0, 511)) - 18'sd256;
		endcase
		return c;
	endfunction

	// check done results in order, record accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_rot.size() == 0) begin
					errors++;
					$display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
						result.rot_x, result.rot_y, result.rot_z, result.saturated);
				end else begin
					want = pending_rot.pop_front();
					if (result.rot_x !== want.rot_x || result.rot_y !== want.rot_y ||
							result.rot_z !== want.rot_z || result.saturated !== want.saturated) begin
						errors++;
						$display("%0t: mismatch exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
							$time, want.rot_x, want.rot_y, want.rot_z, want.saturated,
							result.rot_x, result.rot_y, result.rot_z, result.saturated);
					end
				end
			end
			if (start && !busy)
				pending_rot.push_back(known_sel ? known_rot : rotate_vec(vec));
		end
	end

	// one rotation transaction, then an occasional short idle gap
	task automatic send_vec(input vec_t v, input logic chk, input rot_t known);
		start <= 1'b1;
		vec <= v;
		known_sel <= chk;
		known_rot <= known;
		do
			@(posedge clk);
		while (busy);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	// stop issuing and wait until every result is back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_rot.size() != 0)
			@(posedge clk);
	endtask

	// apb write: setup then access, upper data bits are don't care
	task automatic apb_write(input logic [1:0] idx, input logic signed [QW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {(DATA_WIDTH-QW)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ORIENT_W: ori_w = value;
			REG_ORIENT_X: ori_x = value;
			REG_ORIENT_Y: ori_y = value;
			default: ori_z = value;
		endcase
	endtask

	// reprogram the orientation only with the pipeline empty
	task automatic set_orientation(input logic signed [QW-1:0] qw, input logic signed [QW-1:0] qx,
			input logic signed [QW-1:0] qy, input logic signed [QW-1:0] qz);
		if (qw !== ori_w || qx !== ori_x || qy !== ori_y || qz !== ori_z) begin
			drain();
			apb_write(REG_ORIENT_W, qw);
			apb_write(REG_ORIENT_X, qx);
			apb_write(REG_ORIENT_Y, qy);
			apb_write(REG_ORIENT_Z, qz);
		end
	endtask

	// directed table then random phases
	initial begin
		vec_t rv;
		dir_rows = '{
			// identity after reset: output equals input
			'{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, '{32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd0, 32'sd0, 32'sd0, 1'b0}},
			'{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, '{VEC_MAX, VEC_MAX, VEC_MAX}, 1'b1,
				'{VEC_MAX, VEC_MAX, VEC_MAX, 1'b0}},
			'{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, '{VEC_MIN, VEC_MIN, VEC_MIN}, 1'b1,
				'{VEC_MIN, VEC_MIN, VEC_MIN, 1'b0}},
			'{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, '{32'sd1, V_NEG1, 32'sh1234_5678}, 1'b1,
				'{32'sd1, V_NEG1, 32'sh1234_5678, 1'b0}},
			'{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, '{VEC_MIN, VEC_MAX, 32'sd0}, 1'b1,
				'{VEC_MIN, VEC_MAX, 32'sd0, 1'b0}},
			// zero quaternion collapses everything
			'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, '{VEC_MAX, VEC_MIN, VEC_MAX}, 1'b1,
				'{32'sd0, 32'sd0, 32'sd0, 1'b0}},
			// w = -1.0 is still identity
			'{Q_NONE, Q_ZERO, Q_ZERO, Q_ZERO, '{V_ONE, 32'shFFFE_0000, VEC_MAX}, 1'b1,
				'{V_ONE, 32'shFFFE_0000, VEC_MAX, 1'b0}},
			// w near 2.0 scales by about 4, clamping large vectors
			'{Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, '{VEC_MAX, VEC_MAX, VEC_MAX}, 1'b1,
				'{VEC_MAX, VEC_MAX, VEC_MAX, 1'b1}},
			'{Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, '{VEC_MIN, VEC_MIN, VEC_MIN}, 1'b1,
				'{VEC_MIN, VEC_MIN, VEC_MIN, 1'b1}},
			'{Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, '{32'sd1, 32'sd0, V_NEG1}, 1'b0, '0},
			// w = -2.0 scales by exactly 4, minimum reached without clamping, maximum clamps
			'{Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, '{32'sh1000_0000, 32'sd0, 32'sd0}, 1'b1,
				'{32'sh4000_0000, 32'sd0, 32'sd0, 1'b0}},
			'{Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, '{32'sh2000_0000, 32'shE000_0000, 32'sd0}, 1'b1,
				'{VEC_MAX, VEC_MIN, 32'sd0, 1'b1}},
			// quarter turn about z
			'{Q_C45, Q_ZERO, Q_ZERO, Q_C45, '{V_ONE, 32'sd0, 32'sd0}, 1'b0, '0},
			'{Q_C45, Q_ZERO, Q_ZERO, Q_C45, '{32'sd0, V_ONE, 32'sd0}, 1'b0, '0},
			'{Q_C45, Q_ZERO, Q_ZERO, Q_C45, '{32'sh0012_3456, 32'shFFF0_0000, 32'sh7FFF_0000},
				1'b0, '0},
			// single imaginary parts at the extremes and at 1.0
			'{Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, '{V_ONE, V_ONE, V_ONE}, 1'b0, '0},
			'{Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO, '{32'sh0000_1234, 32'shFFFF_8000, 32'sh0040_0000},
				1'b0, '0},
			'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, '{V_ONE, 32'sh0002_0000, 32'sh0003_0000},
				1'b0, '0},
			// all components at the extremes
			'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, '{32'sd1, V_NEG1, 32'sd1}, 1'b0, '0},
			'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, '{VEC_MAX, VEC_MIN, VEC_MAX}, 1'b0, '0},
			'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, '{V_ONE, 32'shFFFF_0000, 32'sh0000_8000}, 1'b0, '0},
			// tiny w: rounding on and near the half lsb
			'{Q_TINY, Q_ZERO, Q_ZERO, Q_ZERO, '{VEC_MIN, VEC_MAX, V_NEG1}, 1'b0, '0},
			'{Q_TINY, Q_ZERO, Q_ZERO, Q_ZERO, '{32'sh8000_0001, 32'sd1, 32'sd0}, 1'b0, '0},
			// mixed signs, non-unit
			'{Q_ONE, Q_NONE, Q_ONE, Q_NONE, '{32'sh0123_4567, 32'shFEDC_BA98, 32'sh00AB_CDEF},
				1'b0, '0}
		};

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NUM_DIR; i++) begin
			set_orientation(dir_rows[i].qw, dir_rows[i].qx, dir_rows[i].qy, dir_rows[i].qz);
			send_vec(dir_rows[i].v, dir_rows[i].chk, dir_rows[i].known);
		end

		// random phases, two of them without idle gaps
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct = (p == 4 || p == 5) ? 0 : 7;
			set_orientation(rand_quat(), rand_quat(), rand_quat(), rand_quat());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				rv.vec_x = rand_comp();
				rv.vec_y = rand_comp();
				rv.vec_z = rand_comp();
				send_vec(rv, 1'b0, '0);
			end
		end

		// flush and look for stray results
		drain();
		repeat (LATENCY + 4)
			@(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

endmodule
